>>> rtl/glyph_upscale_with_rounding_unit_macros.svh
// Assertion macros for the glyph upscale and rounding unit.
// Included by rtl/glyph_upscale_with_rounding_unit.sv; no other dependencies.
`ifndef GLYPH_UPSCALE_WITH_ROUNDING_UNIT_MACROS_SVH
`define GLYPH_UPSCALE_WITH_ROUNDING_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define GUP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("glyph unit assertion failed");
// checked on every edge, reset included
`define GUP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("glyph unit assertion failed");
`else
`define GUP_ASSERT(lbl, clk, rst, prop)
`define GUP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/gup_pkg.sv
// Shared types, constants and helper functions for the glyph upscale unit.
// Standalone; used by every module under rtl/.
package gup_pkg;

   localparam int SRC_ROWS  = 9;
   localparam int OUT_ROWS  = 20;
   localparam int HALF_ROWS = OUT_ROWS / 2;
   localparam int ROW_W     = 5;
   localparam int PIX_W     = 11;
   localparam int CODE_W    = 8;
   localparam int IDX_W     = 5;
   localparam int MODE_W    = 2;
   localparam int PAIRS     = (PIX_W - 1) / 2;

   localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(OUT_ROWS - 1);
   localparam logic [IDX_W-1:0] HALF_BASE = IDX_W'(HALF_ROWS);

   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UPPER  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd2;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [ROW_W-1:0] src_type;

   typedef struct packed {
      logic              load;
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  scan;
   } rd_ctl_type;

   // every source pixel becomes two adjacent pixels; bit 10 stays clear
   function automatic pix_type widen(input src_type p);
      pix_type w;
      w = '0;
      for (int j = 0; j < ROW_W; j++) begin
         w[2*j]   = p[j];
         w[2*j+1] = p[j];
      end
      return w;
   endfunction

endpackage

>>> rtl/gup_round_lane.sv
// One rounding lane: diagonal smoothing of one scanline against its neighbor row.
// Depends on gup_pkg.
module gup_round_lane (
   input  gup_pkg::pix_type own_pix,
   input  gup_pkg::pix_type other_pix,
   output gup_pkg::pix_type round_pix
);

   assign round_pix[0] = own_pix[0];

   // bit pairs (even hi, odd lo) are independent: the even bit looks at the raw
   // bit below it, the odd bit at the freshly rounded bit above it
   for (genvar p = 0; p < gup_pkg::PAIRS; p++) begin : g_pair
      localparam int HI = 2 * p + 2;
      localparam int LO = 2 * p + 1;
      logic new_hi;
      assign new_hi = own_pix[HI] | (other_pix[HI] & own_pix[LO] & ~other_pix[LO]);
      assign round_pix[HI] = new_hi;
      assign round_pix[LO] = own_pix[LO] | (other_pix[LO] & new_hi & ~other_pix[HI]);
   end

endmodule

>>> rtl/gup_scan_store.sv
// Merge stage: holds the finished scanlines of one item and reads one per cycle.
// Depends on gup_pkg.
module gup_scan_store (
   input  logic                                           clock,
   input  gup_pkg::rd_ctl_type                            ctl,
   input  logic [gup_pkg::OUT_ROWS-1:0][gup_pkg::PIX_W-1:0] rows_in,
   output gup_pkg::pix_type                               pix_out
);

   logic [gup_pkg::OUT_ROWS-1:0][gup_pkg::PIX_W-1:0] rows_ff;
   gup_pkg::pix_type                                 pix_ff;
   logic [gup_pkg::IDX_W-1:0]                        row_sel;
   logic [gup_pkg::IDX_W-1:0]                        half_sel;

   assign half_sel = {1'b0, ctl.scan[gup_pkg::IDX_W-1:1]};

   always_comb begin
      case (ctl.mode)
         gup_pkg::MODE_UPPER: row_sel = half_sel;
         gup_pkg::MODE_LOWER: row_sel = gup_pkg::IDX_W'(gup_pkg::HALF_BASE + half_sel);
         default:             row_sel = ctl.scan;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rows_ff <= rows_in;
      end
      pix_ff <= rows_ff[row_sel];
   end

   assign pix_out = pix_ff;

endmodule

>>> rtl/glyph_upscale_with_rounding_unit.sv
// Top level of the glyph upscale and rounding unit: control, rounding lanes, outputs.
// Depends on gup_pkg, gup_round_lane, gup_scan_store and the assertion macro header.
//
//   channel   ports                                   direction  handshake
//   request   start, busy, req_glyph_code, req_source_row_0..8   in   start & !busy
//   response  rsp_valid, rsp_slot_echo, rsp_scan_index,
//             rsp_scan_pixels, rsp_last_scan          out        rsp_valid, one cycle
//   csr       csr_valid, csr_ready, csr_wdata         in         valid & ready
//
// Each item yields 20 scanlines, one per cycle, paced by the scanline counter. Sixteen
// lanes round scanlines 3 to 18 in the accept cycle. busy drops during the last
// scanline, so the next item enters without a gap. After accept, the first scanline
// passes the control registers, then the output registers. Synchronous reset clears
// control and the height mode. The response side cannot stall; csr_ready is always high.
`include "glyph_upscale_with_rounding_unit_macros.svh"
module glyph_upscale_with_rounding_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gup_pkg::CODE_W-1:0]    req_glyph_code,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_0,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_1,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_2,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_3,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_4,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_5,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_6,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_7,
   input  logic [gup_pkg::ROW_W-1:0]     req_source_row_8,
   output logic                          rsp_valid,
   output logic [gup_pkg::CODE_W-1:0]    rsp_slot_echo,
   output logic [gup_pkg::IDX_W-1:0]     rsp_scan_index,
   output logic [gup_pkg::PIX_W-1:0]     rsp_scan_pixels,
   output logic                          rsp_last_scan,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gup_pkg::MODE_W-1:0]    csr_wdata
);

   logic [gup_pkg::SRC_ROWS-1:0][gup_pkg::ROW_W-1:0] src_rows;
   logic [gup_pkg::OUT_ROWS-1:0][gup_pkg::PIX_W-1:0] fin_rows;

   logic                        accept;
   logic                        active_ff, active_in;
   logic [gup_pkg::IDX_W-1:0]   cnt_ff, cnt_in;
   logic [gup_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [gup_pkg::CODE_W-1:0]  code_ff;
   logic                        valid_ff;
   logic [gup_pkg::CODE_W-1:0]  slot_ff;
   logic [gup_pkg::IDX_W-1:0]   idx_ff;
   logic                        last_ff;
   logic                        at_last;
   gup_pkg::rd_ctl_type         rd_ctl;

   assign src_rows[0] = req_source_row_0;
   assign src_rows[1] = req_source_row_1;
   assign src_rows[2] = req_source_row_2;
   assign src_rows[3] = req_source_row_3;
   assign src_rows[4] = req_source_row_4;
   assign src_rows[5] = req_source_row_5;
   assign src_rows[6] = req_source_row_6;
   assign src_rows[7] = req_source_row_7;
   assign src_rows[8] = req_source_row_8;

   // top two scanlines blank, first and last doubled rows unrounded
   assign fin_rows[0] = '0;
   assign fin_rows[1] = '0;
   assign fin_rows[2] = gup_pkg::widen(src_rows[0]);
   assign fin_rows[gup_pkg::OUT_ROWS-1] = gup_pkg::widen(src_rows[gup_pkg::SRC_ROWS-1]);

   // even scanline rounds against the row above, odd against the row below
   for (genvar r = 3; r < gup_pkg::OUT_ROWS - 1; r++) begin : g_lane
      localparam int SRC_IDX   = (r - 2) / 2;
      localparam int OTHER_IDX = (r % 2 == 0) ? SRC_IDX - 1 : SRC_IDX + 1;
      gup_round_lane u_lane (
         .own_pix   (gup_pkg::widen(src_rows[SRC_IDX])),
         .other_pix (gup_pkg::widen(src_rows[OTHER_IDX])),
         .round_pix (fin_rows[r])
      );
   end

   assign at_last   = (cnt_ff == gup_pkg::LAST_SCAN);
   assign busy      = active_ff & ~at_last;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (active_ff & at_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         cnt_in = gup_pkg::IDX_W'(cnt_ff + 1'b1);
      end
      mode_in = (csr_valid & csr_ready) ? csr_wdata : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         mode_ff   <= gup_pkg::MODE_NORMAL;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         mode_ff   <= mode_in;
         valid_ff  <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= req_glyph_code;
      end
      slot_ff <= code_ff;
      idx_ff  <= cnt_ff;
      last_ff <= at_last;
   end

   assign rd_ctl.load = accept;
   assign rd_ctl.mode = mode_ff;
   assign rd_ctl.scan = cnt_ff;

   gup_scan_store u_store (
      .clock   (clock),
      .ctl     (rd_ctl),
      .rows_in (fin_rows),
      .pix_out (rsp_scan_pixels)
   );

   assign rsp_valid      = valid_ff;
   assign rsp_slot_echo  = slot_ff;
   assign rsp_scan_index = idx_ff;
   assign rsp_last_scan  = last_ff & valid_ff;

   `GUP_ASSERT(a_scan_runs_on, clock, reset, (rsp_valid && !rsp_last_scan) |=> (rsp_valid && rsp_scan_index == gup_pkg::IDX_W'($past(rsp_scan_index) + 1'b1)))
   `GUP_ASSERT(a_accept_first, clock, reset, (start && !busy) |-> ##2 (rsp_valid && rsp_scan_index == '0))
   `GUP_ASSERT(a_last_index, clock, reset, rsp_last_scan |-> (rsp_scan_index == gup_pkg::LAST_SCAN))
   `GUP_ASSERT_ALWAYS(a_idle_slot, clock, (active_ff && !busy) |-> at_last)

endmodule

>>> dv/glyph_upscale_with_rounding_unit_checker.sv
// Scoreboard for the glyph upscale and rounding unit: predicts every scanline
// of each accepted glyph and compares it with the response channel.
// Depends on gup_pkg for widths and height mode codes.
module glyph_upscale_with_rounding_unit_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [gup_pkg::CODE_W-1:0]             req_glyph_code,
   input  logic [gup_pkg::SRC_ROWS-1:0][gup_pkg::ROW_W-1:0] req_rows,
   input  logic                                   rsp_valid,
   input  logic [gup_pkg::CODE_W-1:0]             rsp_slot_echo,
   input  logic [gup_pkg::IDX_W-1:0]              rsp_scan_index,
   input  logic [gup_pkg::PIX_W-1:0]              rsp_scan_pixels,
   input  logic                                   rsp_last_scan,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [gup_pkg::MODE_W-1:0]             csr_wdata,
   output int                                     mismatch_count,
   output int                                     pending_scans,
   output int                                     scans_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import gup_pkg::*;

   typedef logic [SRC_ROWS-1:0][ROW_W-1:0] glyph_rows_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [IDX_W-1:0]  index;
      logic [PIX_W-1:0]  pixels;
      logic              last;
   } scanline_type;

   scanline_type      expected_scans[$];
   logic [MODE_W-1:0] height_mode;
   int                failures;
   int                checked;

   function automatic pix_type double_pixels(input src_type p);
      return {1'b0, p[4], p[4], p[3], p[3], p[2], p[2], p[1], p[1], p[0], p[0]};
   endfunction

   // bits 10..1 in order, so a pixel filled here can enable the next one
   function automatic pix_type round_diagonals(input pix_type cur, input pix_type other);
      pix_type b;
      int      nb;
      b = cur;
      for (int bit_i = PIX_W - 1; bit_i >= 1; bit_i--) begin
         nb = (bit_i % 2 == 0) ? bit_i - 1 : bit_i + 1;
         if (!b[bit_i] && other[bit_i] && b[nb] && !other[nb])
            b[bit_i] = 1'b1;
      end
      return b;
   endfunction

   function automatic void predict_scanlines(input logic [CODE_W-1:0] code,
                                             input glyph_rows_type rows,
                                             input logic [MODE_W-1:0] mode);
      pix_type      raw [OUT_ROWS];
      pix_type      done [OUT_ROWS];
      scanline_type s;
      int           src;
      raw[0] = '0;
      raw[1] = '0;
      for (int r = 0; r < SRC_ROWS; r++) begin
         raw[2*r+2] = double_pixels(rows[r]);
         raw[2*r+3] = double_pixels(rows[r]);
      end
      for (int r = 0; r < OUT_ROWS; r++) begin
         if (r > 2 && r < OUT_ROWS - 1)
            done[r] = round_diagonals(raw[r], (r % 2 == 0) ? raw[r-1] : raw[r+1]);
         else
            done[r] = raw[r];
      end
      for (int r = 0; r < OUT_ROWS; r++) begin
         case (mode)
            MODE_UPPER: src = r / 2;
            MODE_LOWER: src = HALF_ROWS + r / 2;
            default:    src = r;
         endcase
         s.code   = code;
         s.index  = IDX_W'(r);
         s.pixels = done[src];
         s.last   = (r == OUT_ROWS - 1);
         expected_scans.push_back(s);
      end
   endfunction

   always @(posedge clock) begin
      scanline_type want;
      if (reset) begin
         expected_scans.delete();
         height_mode = MODE_NORMAL;
         failures = 0;
         checked = 0;
      end else begin
         if (csr_valid && csr_ready)
            height_mode = csr_wdata;
         if (start && !busy)
            predict_scanlines(req_glyph_code, req_rows, height_mode);
         if (rsp_valid) begin
            if (expected_scans.size() == 0) begin
               if (failures < 10)
                  $display("unexpected scanline: code %0d idx %0d pix %03h last %0b",
                           rsp_slot_echo, rsp_scan_index, rsp_scan_pixels, rsp_last_scan);
               failures++;
            end else begin
               want = expected_scans.pop_front();
               checked++;
               if (rsp_slot_echo !== want.code || rsp_scan_index !== want.index ||
                   rsp_scan_pixels !== want.pixels || rsp_last_scan !== want.last) begin
                  if (failures < 10)
                     $display("scanline mismatch: exp code %0d idx %0d pix %03h last %0b, got code %0d idx %0d pix %03h last %0b",
                              want.code, want.index, want.pixels, want.last,
                              rsp_slot_echo, rsp_scan_index, rsp_scan_pixels,
                              rsp_last_scan);
                  failures++;
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_scans  <= expected_scans.size();
      scans_checked  <= checked;
   end

endmodule

>>> dv/glyph_upscale_with_rounding_unit_test.sv
// Testbench top for the glyph upscale and rounding unit: clock, reset,
// directed and random glyph stimulus, height mode changes and the verdict.
// Depends on gup_pkg, the unit RTL and glyph_upscale_with_rounding_unit_checker.
module glyph_upscale_with_rounding_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gup_pkg::*;

   typedef logic [SRC_ROWS-1:0][ROW_W-1:0] glyph_rows_type;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int RUN_LIMIT    = 100000;
   localparam int DRAIN_SLACK  = 4;
   localparam int PHASE_ITEMS  = 21;
   localparam int RANDOM_PHASES = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CODE_W-1:0]   req_glyph_code = '0;
   glyph_rows_type      req_rows = '0;
   logic                rsp_valid;
   logic [CODE_W-1:0]   rsp_slot_echo;
   logic [IDX_W-1:0]    rsp_scan_index;
   logic [PIX_W-1:0]    rsp_scan_pixels;
   logic                rsp_last_scan;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MODE_W-1:0]   csr_wdata = '0;

   int mismatch_count;
   int pending_scans;
   int scans_checked;
   int glyphs_sent = 0;
   int cycle_count = 0;

   glyph_upscale_with_rounding_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_glyph_code   (req_glyph_code),
      .req_source_row_0 (req_rows[0]),
      .req_source_row_1 (req_rows[1]),
      .req_source_row_2 (req_rows[2]),
      .req_source_row_3 (req_rows[3]),
      .req_source_row_4 (req_rows[4]),
      .req_source_row_5 (req_rows[5]),
      .req_source_row_6 (req_rows[6]),
      .req_source_row_7 (req_rows[7]),
      .req_source_row_8 (req_rows[8]),
      .rsp_valid        (rsp_valid),
      .rsp_slot_echo    (rsp_slot_echo),
      .rsp_scan_index   (rsp_scan_index),
      .rsp_scan_pixels  (rsp_scan_pixels),
      .rsp_last_scan    (rsp_last_scan),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   glyph_upscale_with_rounding_unit_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_glyph_code  (req_glyph_code),
      .req_rows        (req_rows),
      .rsp_valid       (rsp_valid),
      .rsp_slot_echo   (rsp_slot_echo),
      .rsp_scan_index  (rsp_scan_index),
      .rsp_scan_pixels (rsp_scan_pixels),
      .rsp_last_scan   (rsp_last_scan),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_scans   (pending_scans),
      .scans_checked   (scans_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d scanlines outstanding",
                  cycle_count, pending_scans);
         $display("** glyph_upscale_with_rounding_unit: FAILED **");
         $finish;
      end
   end

   function automatic glyph_rows_type pattern_rows(input int k);
      glyph_rows_type rows;
      for (int r = 0; r < SRC_ROWS; r++) begin
         case (k)
            0: rows[r] = 5'h00;
            1: rows[r] = 5'h1F;
            2: rows[r] = (r % 2 == 0) ? 5'h15 : 5'h0A;
            3: rows[r] = 5'(5'h10 >> (r % 5));
            4: rows[r] = 5'(5'h01 << (r % 5));
            5: rows[r] = (r == 4) ? 5'h04 : 5'h00;
            6: rows[r] = (r % 2 == 0) ? 5'h1F : 5'h00;
            default: rows[r] = 5'((5'h10 >> (r % 5)) | (5'h01 << (r % 5)));
         endcase
      end
      return rows;
   endfunction

   // six in ten fully random, else a stroke that wanders one column per row, so rounding fires often
   function automatic glyph_rows_type random_rows();
      glyph_rows_type rows;
      int pos;
      if ($urandom_range(0, 9) < 6) begin
         for (int r = 0; r < SRC_ROWS; r++)
            rows[r] = 5'($urandom);
      end else begin
         pos = $urandom_range(0, ROW_W - 1);
         for (int r = 0; r < SRC_ROWS; r++) begin
            rows[r] = 5'(5'h01 << pos);
            if ($urandom_range(0, 3) == 0)
               rows[r] = rows[r] | 5'($urandom);
            if ($urandom_range(0, 1) == 0)
               pos = (pos == ROW_W - 1) ? pos - 1 : pos + 1;
            else
               pos = (pos == 0) ? pos + 1 : pos - 1;
         end
      end
      return rows;
   endfunction

   // returns at the edge that accepted the item; start stays high
   task automatic send_glyph(input logic [CODE_W-1:0] code, input glyph_rows_type rows);
      start          <= 1'b1;
      req_glyph_code <= code;
      req_rows       <= rows;
      do @(posedge clock); while (busy);
      glyphs_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start          <= 1'b0;
      req_glyph_code <= CODE_W'($urandom);
      req_rows       <= random_rows();
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_scans != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic set_height_mode(input logic [MODE_W-1:0] mode);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [MODE_W-1:0] phase_mode;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every pattern in the reset mode, then a subset per mode
      for (int k = 0; k < 8; k++)
         send_glyph((k == 1) ? 8'hFF : CODE_W'(k * 37), pattern_rows(k));
      set_height_mode(MODE_UPPER);
      for (int k = 0; k < 5; k++)
         send_glyph(8'hF0 + CODE_W'(k), pattern_rows(k + 2));
      set_height_mode(MODE_LOWER);
      for (int k = 0; k < 5; k++)
         send_glyph(8'hE0 + CODE_W'(k), pattern_rows(k + 2));
      set_height_mode(MODE_SPARE);
      for (int k = 0; k < 5; k++)
         send_glyph(8'hD0 + CODE_W'(k), pattern_rows(k + 2));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: phase_mode = MODE_LOWER;
            1: phase_mode = MODE_UPPER;
            2: phase_mode = MODE_SPARE;
            3: phase_mode = MODE_NORMAL;
            4: phase_mode = MODE_W'($urandom_range(0, 3));
            default: phase_mode = MODE_LOWER;
         endcase
         set_height_mode(phase_mode);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_glyph(CODE_W'($urandom), random_rows());
            if (p == 1 && i == PHASE_ITEMS / 2)
               wait_drained();
            else if (p < RANDOM_PHASES - 1 && $urandom_range(0, 2) == 0)
               pause_sender($urandom_range(1, 12));
         end
      end

      wait_drained();
      $display("run covered %0d glyphs over normal, upper, lower and spare height modes",
               glyphs_sent);
      $display("%0d scanlines checked, %0d mismatches", scans_checked, mismatch_count);
      if (mismatch_count == 0 && pending_scans == 0)
         $display("** glyph_upscale_with_rounding_unit: PASSED **");
      else
         $display("** glyph_upscale_with_rounding_unit: FAILED **");
      $finish;
   end

endmodule
